// ----- rtl/core/tmp_pkg.sv -----
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and codes of the trapezoidal motion profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int unsigned SPEED_W = 31;
  localparam int unsigned TPER_W  = 24;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_ACCEL   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TICK_PERIOD = 2'd2;

  localparam logic REQ_TARGET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_HOLD   = 2'd3;

  // command to the shared divide / square root unit
  typedef struct packed {
    logic               go;
    logic               sqrt;
    logic [63:0]        num;
    logic [5:0]         sh;
    logic [SPEED_W-1:0] den;
  } ds_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q_sat;
  } ds_res_t;

endpackage

// ----- rtl/core/tmp_divsqrt.sv -----
// ----------------------------------------------------------------------------
// tmp_divsqrt
// Bit-serial unit: floor(num * 2^sh / den) saturated to 64 bits, one quotient
// bit per cycle, or floor(sqrt(num)), one root bit per cycle.
// ----------------------------------------------------------------------------
module tmp_divsqrt (
  input  logic             clk,
  input  logic             rst,
  input  tmp_pkg::ds_cmd_t cmd,
  output tmp_pkg::ds_res_t res
);

  logic                        busy;
  logic                        done;
  logic                        mode_sqrt;
  logic [63:0]                 src;
  logic [tmp_pkg::SPEED_W-1:0] den_r;
  logic [34:0]                 rem;
  logic [63:0]                 q;
  logic                        ovf;
  logic [6:0]                  cnt;

  logic [36:0] op_a;
  logic [36:0] op_b;
  logic [37:0] diff;
  logic        ge;
  logic [34:0] rem_next;

  always_comb begin
    if (mode_sqrt) begin
      op_a = {rem, src[63:62]};
      op_b = {3'b0, q[31:0], 2'b01};
    end else begin
      op_a = {5'b0, rem[30:0], src[63]};
      op_b = {6'b0, den_r};
    end
    diff     = {1'b0, op_a} - {1'b0, op_b};
    ge       = ~diff[37];
    rem_next = ge ? diff[34:0] : op_a[34:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (cmd.go) begin
        busy      <= 1'b1;
        mode_sqrt <= cmd.sqrt;
        src       <= cmd.num;
        den_r     <= cmd.den;
        rem       <= '0;
        q         <= '0;
        ovf       <= 1'b0;
        cnt       <= cmd.sqrt ? 7'd32 : (7'd64 + {1'b0, cmd.sh});
      end else if (busy) begin
        rem <= rem_next;
        q   <= {q[62:0], ge};
        if (!mode_sqrt) begin
          ovf <= ovf | q[63];
          src <= {src[62:0], 1'b0};
        end else begin
          src <= {src[61:0], 2'b00};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.q_sat = ovf ? '1 : q;

endmodule

// ----- rtl/core/trapezoid_motion_profile.sv -----
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Position setpoint generator with trapezoidal or triangular velocity
// profile, planned on a shared bit-serial divide / square root unit.
//
//   channel | signals                                   | dir
//   in      | in_valid in_stall req_type target/current | in
//   out     | out_valid out_stall setpoint_position phase | out
//   cfg     | cfg_write cfg_index cfg_data              | in
//
// A tick item passes through ST_T_PH, ST_T_M1, ST_T_M2, ST_T_M3 and ST_T_OUT
// (shared multiplier used three times) and waits in ST_T_OUT while stalled.
// A new-target item is planned by the one-bit-per-cycle divide / square root
// unit (64 + shift steps per divide, 32 steps per root): a triangular move
// uses two divides and a root, a trapezoid move three divides.
// One item at a time; in_stall is high while an item is being worked.
// Synchronous reset clears the move state; a tick before any target holds 0.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic signed [POS_BITS-1:0]  target_position,
  input  logic signed [POS_BITS-1:0]  current_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [POS_BITS-1:0]  setpoint_position,
  output logic [1:0]                  phase,
  input  logic                        cfg_write,
  input  logic [tmp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [tmp_pkg::CFG_W-1:0]   cfg_data
);

  localparam int unsigned SW    = tmp_pkg::SPEED_W;
  localparam int unsigned SUM_W = ((POS_BITS > 41) ? POS_BITS : 41) + 2;

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_PL_VV  = 17'h00002,
    ST_PL_DAC = 17'h00004,
    ST_W_DAC  = 17'h00008,
    ST_PL_BR  = 17'h00010,
    ST_W_TRI  = 17'h00020,
    ST_W_SQRT = 17'h00040,
    ST_PL_PK  = 17'h00080,
    ST_PL_PKW = 17'h00100,
    ST_W_TA   = 17'h00200,
    ST_W_TC   = 17'h00400,
    ST_FIN    = 17'h00800,
    ST_T_PH   = 17'h01000,
    ST_T_M1   = 17'h02000,
    ST_T_M2   = 17'h04000,
    ST_T_M3   = 17'h08000,
    ST_T_OUT  = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SW-1:0]                 max_speed;
  logic [SW-1:0]                 max_accel;
  logic [tmp_pkg::TPER_W-1:0]    tick_period;

  logic signed [POS_BITS-1:0]    start_pos;
  logic signed [POS_BITS-1:0]    end_pos;
  logic signed [POS_BITS-1:0]    held;
  logic [31:0]                   ta;
  logic [31:0]                   tc;
  logic [31:0]                   tm;
  logic [31:0]                   elapsed;
  logic [SW-1:0]                 am;
  logic [SW-1:0]                 vm;
  logic                          neg;

  logic [SW-1:0]                 vw;
  logic [SW-1:0]                 aw;
  logic [POS_BITS:0]             span;
  logic [61:0]                   dacc;

  logic [1:0]                    ph;
  logic [31:0]                   tt;
  logic [31:0]                   dt;
  logic [40:0]                   mag;
  logic [40:0]                   mag_total;

  logic [31:0]                   mul_a;
  logic [31:0]                   mul_b;
  logic [63:0]                   prod;

  tmp_pkg::ds_cmd_t              ds_cmd;
  tmp_pkg::ds_res_t              ds_res;

  logic                          in_acc;
  logic signed [POS_BITS:0]      diff;
  logic [32:0]                   t_sum;
  logic [31:0]                   t_new;
  logic [32:0]                   cruise_end;
  logic [31:0]                   q32;
  logic [31:0]                   psat;
  logic [39:0]                   pk_full;
  logic [33:0]                   tm_sum;
  logic signed [SUM_W-1:0]       base;
  logic signed [SUM_W-1:0]       sum;
  logic signed [POS_BITS-1:0]    x;
  logic                          out_free;

  tmp_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .cmd (ds_cmd),
    .res (ds_res)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    diff       = {target_position[POS_BITS-1], target_position}
               - {current_position[POS_BITS-1], current_position};
    t_sum      = {1'b0, elapsed} + {9'b0, tick_period};
    t_new      = t_sum[32] ? '1 : t_sum[31:0];
    cruise_end = {1'b0, ta} + {1'b0, tc};
    q32        = (|ds_res.q_sat[63:32]) ? '1 : ds_res.q_sat[31:0];
    psat       = (|prod[63:56]) ? '1 : prod[55:24];
    pk_full    = prod[63:24];
    tm_sum     = {1'b0, ta, 1'b0} + {2'b0, tc};
  end

  always_comb begin
    unique case (state)
      ST_PL_VV: begin
        mul_a = {1'b0, vw};
        mul_b = {1'b0, vw};
      end
      ST_PL_PK: begin
        mul_a = {1'b0, aw};
        mul_b = ta;
      end
      ST_T_M1: begin
        mul_a = {1'b0, am};
        mul_b = tt;
      end
      ST_T_M2: begin
        mul_a = psat;
        mul_b = tt;
      end
      ST_T_M3, ST_T_OUT: begin
        mul_a = {1'b0, vm};
        mul_b = dt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    ds_cmd = '0;
    ds_cmd.den = aw;
    unique case (state)
      ST_PL_DAC: begin
        ds_cmd.go  = 1'b1;
        ds_cmd.num = prod;
      end
      ST_PL_BR: begin
        ds_cmd.go = 1'b1;
        if ({2'b0, dacc} >= 64'(span)) begin
          ds_cmd.num = 64'(span);
          ds_cmd.sh  = 6'd48;
        end else begin
          ds_cmd.num = 64'(vw);
          ds_cmd.sh  = 6'd24;
        end
      end
      ST_W_TRI: begin
        ds_cmd.go   = ds_res.done;
        ds_cmd.sqrt = 1'b1;
        ds_cmd.num  = ds_res.q_sat;
      end
      ST_W_TA: begin
        ds_cmd.go  = ds_res.done;
        ds_cmd.num = 64'(span) - {2'b0, dacc};
        ds_cmd.sh  = 6'd24;
        ds_cmd.den = vw;
      end
      default: begin
      end
    endcase
  end

  // cruise adds the constant-speed distance held in the last product
  always_comb begin
    mag_total = mag + {2'b0, prod[62:24]};
    base = (ph == tmp_pkg::PH_DECEL) ? SUM_W'(end_pos) : SUM_W'(start_pos);
    if (neg ^ (ph == tmp_pkg::PH_DECEL)) begin
      sum = base - $signed({{(SUM_W-41){1'b0}}, mag_total});
    end else begin
      sum = base + $signed({{(SUM_W-41){1'b0}}, mag_total});
    end
    if (ph == tmp_pkg::PH_HOLD) begin
      x = held;
    end else if ((&sum[SUM_W-1:POS_BITS-1]) || !(|sum[SUM_W-1:POS_BITS-1])) begin
      x = sum[POS_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      x = {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      x = {1'b0, {(POS_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (req_type == tmp_pkg::REQ_TICK) ? ST_T_PH : ST_PL_VV;
        end
      end
      ST_PL_VV:  state_next = ST_PL_DAC;
      ST_PL_DAC: state_next = ST_W_DAC;
      ST_W_DAC:  if (ds_res.done) state_next = ST_PL_BR;
      ST_PL_BR:  state_next = ({2'b0, dacc} >= 64'(span)) ? ST_W_TRI : ST_W_TA;
      ST_W_TRI:  if (ds_res.done) state_next = ST_W_SQRT;
      ST_W_SQRT: if (ds_res.done) state_next = ST_PL_PK;
      ST_PL_PK:  state_next = ST_PL_PKW;
      ST_PL_PKW: state_next = ST_FIN;
      ST_W_TA:   if (ds_res.done) state_next = ST_W_TC;
      ST_W_TC:   if (ds_res.done) state_next = ST_FIN;
      ST_FIN:    state_next = ST_IDLE;
      ST_T_PH:   state_next = ST_T_M1;
      ST_T_M1:   state_next = ST_T_M2;
      ST_T_M2:   state_next = ST_T_M3;
      ST_T_M3:   state_next = ST_T_OUT;
      ST_T_OUT:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      max_speed   <= SW'(65536);
      max_accel   <= SW'(65536);
      tick_period <= tmp_pkg::TPER_W'(1678);
      start_pos   <= '0;
      end_pos     <= '0;
      held        <= '0;
      ta          <= '0;
      tc          <= '0;
      tm          <= '0;
      elapsed     <= '0;
      am          <= '0;
      vm          <= '0;
      neg         <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != ST_T_OUT) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          tmp_pkg::CFG_MAX_SPEED:   max_speed   <= cfg_data;
          tmp_pkg::CFG_MAX_ACCEL:   max_accel   <= cfg_data;
          tmp_pkg::CFG_TICK_PERIOD: tick_period <= cfg_data[tmp_pkg::TPER_W-1:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (req_type == tmp_pkg::REQ_TICK) begin
              elapsed <= t_new;
            end else begin
              neg       <= diff[POS_BITS];
              span      <= diff[POS_BITS] ? -diff : diff;
              vw        <= (max_speed == '0) ? SW'(1) : max_speed;
              aw        <= (max_accel == '0) ? SW'(1) : max_accel;
              start_pos <= current_position;
              end_pos   <= target_position;
              held      <= current_position;
              elapsed   <= '0;
            end
          end
        end
        ST_W_DAC: begin
          if (ds_res.done) dacc <= ds_res.q_sat[61:0];
        end
        ST_W_SQRT: begin
          if (ds_res.done) begin
            ta <= ds_res.q_sat[31:0];
            tc <= '0;
          end
        end
        ST_PL_PKW: begin
          vm <= (pk_full > 40'(vw)) ? vw : pk_full[SW-1:0];
        end
        ST_W_TA: begin
          if (ds_res.done) ta <= q32;
        end
        ST_W_TC: begin
          if (ds_res.done) begin
            tc <= q32;
            vm <= vw;
          end
        end
        ST_FIN: begin
          tm <= (|tm_sum[33:32]) ? '1 : tm_sum[31:0];
          am <= aw;
        end
        ST_T_PH: begin
          if (elapsed <= ta) begin
            ph <= tmp_pkg::PH_ACCEL;
            tt <= elapsed;
            dt <= '0;
          end else if ({1'b0, elapsed} <= cruise_end) begin
            ph <= tmp_pkg::PH_CRUISE;
            tt <= ta;
            dt <= elapsed - ta;
          end else if (elapsed <= tm) begin
            ph <= tmp_pkg::PH_DECEL;
            tt <= tm - elapsed;
            dt <= '0;
          end else begin
            ph <= tmp_pkg::PH_HOLD;
            tt <= '0;
            dt <= '0;
          end
        end
        ST_T_M3: begin
          mag <= {2'b0, prod[63:25]};
        end
        ST_T_OUT: begin
          if (out_free) begin
            held              <= x;
            setpoint_position <= x;
            phase             <= ph;
            out_valid         <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- test/trapezoid_motion_profile_tb.sv -----
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_tb
// Self-checking bench for the trapezoidal motion profile generator. Moves
// and ticks are driven under several idle and stall patterns and register
// settings; each setpoint and phase is compared with a cycle-free predictor.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_tb;

  localparam logic [tmp_pkg::CIDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic signed [31:0] setpoint;
    logic [1:0]         ph;
  } setpoint_t;

  class profile_scoreboard;
    longint unsigned spd, acc, tper;
    longint signed   start_p, end_p, held, pk, sa;
    longint unsigned t_acc, t_cru, t_mov, t_el;
    setpoint_t       pending[$];
    int              errors;

    function new();
      spd = 65536; acc = 65536; tper = 1678;
      start_p = 0; end_p = 0; held = 0; pk = 0; sa = 0;
      t_acc = 0; t_cru = 0; t_mov = 0; t_el = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [tmp_pkg::CIDX_W-1:0] idx,
                            logic [tmp_pkg::CFG_W-1:0] data);
      if (idx == tmp_pkg::CFG_MAX_SPEED) spd = 64'(data);
      else if (idx == tmp_pkg::CFG_MAX_ACCEL) acc = 64'(data);
      else if (idx == tmp_pkg::CFG_TICK_PERIOD) tper = 64'(data[tmp_pkg::TPER_W-1:0]);
    endfunction

    function longint unsigned sat32(longint unsigned x);
      return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
    endfunction

    function longint unsigned scaled_div(longint unsigned num, int sh,
                                         longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < sh; i++) begin
        if (q[63]) return 64'hFFFF_FFFF_FFFF_FFFF;
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint unsigned ramp_dist(longint unsigned a, longint unsigned t);
      longint unsigned p;
      p = sat32((a * t) >> 24);
      return (p * t) >> 25;
    endfunction

    function void note_input(logic rt, logic signed [31:0] tgt,
                             logic signed [31:0] cur);
      longint unsigned v, a, d, dacc, peak, am, vm, t, mag;
      longint signed diff, x;
      logic [1:0] ph;
      bit neg;
      setpoint_t e;
      v = (spd != 0) ? spd : 1;
      a = (acc != 0) ? acc : 1;
      if (rt == tmp_pkg::REQ_TARGET) begin
        diff = longint'(tgt) - longint'(cur);
        neg = diff < 0;
        d = neg ? -diff : diff;
        dacc = (v * v) / a;
        if (dacc >= d) begin
          t_acc = sat32(int_sqrt(scaled_div(d, 48, a)));
          t_cru = 0;
          peak = (a * t_acc) >> 24;
          if (peak > v) peak = v;
        end else begin
          t_acc = sat32(scaled_div(v, 24, a));
          t_cru = sat32(scaled_div(d - dacc, 24, v));
          peak = v;
        end
        t_mov = sat32(2 * t_acc + t_cru);
        t_el = 0;
        pk = neg ? -longint'(peak) : longint'(peak);
        sa = neg ? -longint'(a) : longint'(a);
        start_p = longint'(cur);
        end_p = longint'(tgt);
        held = longint'(cur);
        return;
      end
      t = sat32(t_el + tper);
      am = (sa < 0) ? -sa : sa;
      vm = (pk < 0) ? -pk : pk;
      neg = sa < 0;
      t_el = t;
      if (t <= t_acc) begin
        ph = tmp_pkg::PH_ACCEL;
        mag = ramp_dist(am, t);
        x = start_p + (neg ? -longint'(mag) : longint'(mag));
      end else if (t <= t_acc + t_cru) begin
        ph = tmp_pkg::PH_CRUISE;
        mag = ramp_dist(am, t_acc) + ((vm * (t - t_acc)) >> 24);
        x = start_p + (neg ? -longint'(mag) : longint'(mag));
      end else if (t <= t_mov) begin
        ph = tmp_pkg::PH_DECEL;
        mag = ramp_dist(am, t_mov - t);
        x = end_p - (neg ? -longint'(mag) : longint'(mag));
      end else begin
        ph = tmp_pkg::PH_HOLD;
        x = held;
      end
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      held = x;
      e.setpoint = x[31:0];
      e.ph = ph;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] sp, logic [1:0] ph);
      setpoint_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected setpoint %0d phase %0d", sp, ph);
        return;
      end
      e = pending.pop_front();
      if (sp !== e.setpoint || ph !== e.ph) begin
        errors++;
        if (errors <= 10)
          $display("setpoint mismatch: exp %0d/%0d got %0d/%0d",
                   e.setpoint, e.ph, sp, ph);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, req_type;
  logic signed [31:0] target_position, current_position;
  logic out_valid, out_stall;
  logic signed [31:0] setpoint_position;
  logic [1:0] phase;
  logic cfg_write;
  logic [tmp_pkg::CIDX_W-1:0] cfg_index;
  logic [tmp_pkg::CFG_W-1:0] cfg_data;

  profile_scoreboard sb;
  int unsigned idle_pct, stall_pct, n_items;

  trapezoid_motion_profile dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .target_position(target_position), .current_position(current_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .setpoint_position(setpoint_position), .phase(phase),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(setpoint_position, phase);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(logic rt, logic signed [31:0] tgt, logic signed [31:0] cur);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    target_position <= tgt;
    current_position <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(rt, tgt, cur);
    n_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_regs(logic [tmp_pkg::CFG_W-1:0] v, logic [tmp_pkg::CFG_W-1:0] a,
                          logic [tmp_pkg::CFG_W-1:0] tp);
    logic [tmp_pkg::CFG_W-1:0] vals[3];
    logic [tmp_pkg::CIDX_W-1:0] idx[3];
    vals = '{v, a, tp};
    idx = '{tmp_pkg::CFG_MAX_SPEED, tmp_pkg::CFG_MAX_ACCEL, tmp_pkg::CFG_TICK_PERIOD};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_move(logic signed [31:0] tgt, logic signed [31:0] cur, int ticks);
    send_item(tmp_pkg::REQ_TARGET, tgt, cur);
    for (int i = 0; i < ticks; i++) send_item(tmp_pkg::REQ_TICK, $urandom, $urandom);
  endtask

  initial begin
    #30000000;
    $display("trapezoid_motion_profile verification failed");
    $finish;
  end

  initial begin
    longint signed cur, span, tgt;
    longint unsigned tcount;
    int unsigned mode, ticks;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0; req_type = 1'b0;
    target_position = '0; current_position = '0;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    idle_pct = 0; stall_pct = 0; n_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: ticks before any move, zero-length move, extremes
    for (int i = 0; i < 3; i++)
      send_item(tmp_pkg::REQ_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000);
    run_move(32'sh1234_5678, 32'sh1234_5678, 2);
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'hFF_FFFF);
    run_move(32'sh7FFF_FFFF, 32'sh8000_0000, 4);
    run_move(32'sh8000_0000, 32'sh7FFF_FFFF, 4);
    set_regs(31'd0, 31'd0, 31'd1);
    run_move(32'sh0000_0100, 32'sh0, 2);
    set_regs(31'd1, 31'd1, 31'd1);
    run_move(-32'sh0000_0010, 32'sh0, 2);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_UNUSED_IDX;
    cfg_data <= 31'h5555_5555;
    @(posedge clk);
    cfg_write <= 1'b0;

    // elapsed time runs into saturation while holding
    set_regs(31'd1, 31'd1, 31'hFF_FFFF);
    run_move(32'sh1, 32'sh0, 260);

    mode = 0;
    while (n_items < 850) begin
      case (mode % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (mode % 5 == 4)
        set_regs(31'($urandom_range(1, 32'h7FFF_FFFF)),
                 31'($urandom_range(1, 32'h7FFF_FFFF)),
                 31'($urandom_range(1, 24'hFF_FFFF)));
      else
        set_regs(31'($urandom_range(1 << 14, 1 << 26)),
                 31'($urandom_range(1 << 14, 1 << 26)),
                 31'($urandom_range(1 << 18, 1 << 23)));
      mode++;
      for (int m = 0; m < 5 && n_items < 850; m++) begin
        cur = longint'($signed($urandom));
        case ($urandom_range(0, 9))
          0: span = 0;
          1, 2: span = longint'($signed($urandom)) - cur;
          default: span = longint'($urandom_range(0, 1 << 22)) - 64'sd2097152;
        endcase
        tgt = cur + span;
        if (tgt > 64'sd2147483647) tgt = 64'sd2147483647;
        if (tgt < -64'sd2147483648) tgt = -64'sd2147483648;
        send_item(tmp_pkg::REQ_TARGET, tgt[31:0], cur[31:0]);
        tcount = (sb.tper != 0) ? sb.t_mov / sb.tper : 60;
        ticks = (tcount > 56) ? 56 : 32'(tcount);
        ticks = ticks + $urandom_range(1, 4);
        if ($urandom_range(0, 6) == 0) ticks = $urandom_range(0, ticks);
        for (int i = 0; i < ticks; i++)
          send_item(tmp_pkg::REQ_TICK, $urandom, $urandom);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("trapezoid_motion_profile verification clean");
    end else begin
      $display("trapezoid_motion_profile verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tmp_pkg.sv
rtl/core/tmp_divsqrt.sv
rtl/core/trapezoid_motion_profile.sv
test/trapezoid_motion_profile_tb.sv
